// ===== hdl/igw_pkg.sv =====
// Shared types, constants and helpers for the implicit graph walker.
`default_nettype none
package igw_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_BITS     = 6;

    typedef enum logic [2:0] {
        ACT_BYTE  = 3'd0,
        ACT_END   = 3'd1,
        ACT_DFS   = 3'd2,
        ACT_BFS   = 3'd3,
        ACT_CLEAR = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_VISIT     = 2'd0,
        ST_BAD_START = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]           action;
        logic [7:0]           char_code;
        logic [NODE_BITS-1:0] start_node;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [NODE_BITS-1:0] node;
        logic                 last;
    } t_out_item;

    // Per-node key: vowel count and first byte.
    typedef struct packed {
        logic [7:0] vowels;
        logic [7:0] first;
    } t_key;

    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UZ      = 8'h5A;
    localparam logic [7:0] CASE_OFS   = 8'h20;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] VOWEL_SAT  = 8'hFF;

    function automatic logic is_vowel(input logic [7:0] c);
        logic [7:0] l;
        l = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
        return (l == CH_A) || (l == CH_E) || (l == CH_I) || (l == CH_O) || (l == CH_U);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/igw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module igw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/igw_name_acc.sv =====
// Name accumulator: vowel count and first byte of the name being built.
`default_nettype none
module igw_name_acc (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_byte_en,
    input  wire               i_name_clr,
    input  wire  [7:0]        i_char,
    output igw_pkg::t_key     o_key
);
    import igw_pkg::*;

    t_key r_key, n_key;
    logic r_has, n_has;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_has <= 1'b0;
        end else begin
            r_key <= n_key;
            r_has <= n_has;
        end
    end

    always_comb begin
        n_key = r_key;
        n_has = r_has;
        if (i_name_clr) begin
            n_key = '0;
            n_has = 1'b0;
        end else if (i_byte_en) begin
            if (!r_has) begin
                n_key.first = i_char;
                n_has       = 1'b1;
            end
            // saturate the count
            if (is_vowel(i_char) && r_key.vowels != VOWEL_SAT) begin
                n_key.vowels = r_key.vowels + 8'd1;
            end
        end
    end

    assign o_key = r_key;
endmodule
`default_nettype wire

// ===== hdl/igw_walk.sv =====
// Walk sequencer: BFS/DFS over stored keys with one shared compare unit.
`default_nettype none
module igw_walk #(
    parameter int MAX_NODES = igw_pkg::MAX_NODES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_go,
    input  wire                              i_dfs,
    input  wire  [$clog2(MAX_NODES)-1:0]     i_start,
    input  wire  [$clog2(MAX_NODES+1)-1:0]   i_count,
    output logic [$clog2(MAX_NODES)-1:0]     o_key_addr,
    input  igw_pkg::t_key                    i_key_rdata,
    output logic                             o_busy,
    output logic                             o_res_valid,
    output igw_pkg::t_out_item               o_res
);
    import igw_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_KEYRD,
        WS_SCAN,
        WS_EMIT,
        WS_POPRD
    } t_walk_state;

    t_walk_state            r_state, n_state;
    logic                   r_dfs, n_dfs;
    logic [NW-1:0]          r_cur, n_cur;
    t_key                   r_cur_key, n_cur_key;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_pv, n_pv;
    logic [NW-1:0]          r_pidx, n_pidx;
    logic [CW-1:0]          r_wp, n_wp;
    logic [CW-1:0]          r_head, n_head;
    logic [MAX_NODES-1:0]   r_vis, n_vis;
    logic                   r_res_valid, n_res_valid;
    t_out_item              r_res, n_res;

    logic                   wl_we;
    logic [NW-1:0]          wl_waddr;
    logic [NW-1:0]          wl_raddr;
    logic [NW-1:0]          wl_rdata;
    logic                   issue;
    logic [NW-1:0]          scan_addr;
    logic                   empty;
    logic [CW-1:0]          wp_dec;

    igw_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_work_list (
        .i_clk   (i_clk),
        .i_we    (wl_we),
        .i_waddr (wl_waddr),
        .i_wdata (r_pidx),
        .i_raddr (wl_raddr),
        .o_rdata (wl_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WS_IDLE;
            r_vis       <= '0;
            r_res_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vis       <= n_vis;
            r_res_valid <= n_res_valid;
            r_pv        <= n_pv;
        end
        r_dfs     <= n_dfs;
        r_cur     <= n_cur;
        r_cur_key <= n_cur_key;
        r_cnt     <= n_cnt;
        r_pidx    <= n_pidx;
        r_wp      <= n_wp;
        r_head    <= n_head;
        r_res     <= n_res;
    end

    assign issue     = r_cnt < i_count;
    assign scan_addr = r_dfs ? NW'(i_count - CW'(1) - r_cnt) : NW'(r_cnt);
    assign wp_dec    = r_wp - CW'(1);
    assign empty     = r_dfs ? (r_wp == '0) : (r_head == r_wp);

    always_comb begin
        n_state     = r_state;
        n_dfs       = r_dfs;
        n_cur       = r_cur;
        n_cur_key   = r_cur_key;
        n_cnt       = r_cnt;
        n_pv        = 1'b0;
        n_pidx      = r_pidx;
        n_wp        = r_wp;
        n_head      = r_head;
        n_vis       = r_vis;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_key_addr  = scan_addr;
        wl_we       = 1'b0;
        wl_waddr    = NW'(r_wp);
        wl_raddr    = r_dfs ? NW'(wp_dec) : NW'(r_head);

        case (r_state)
            WS_IDLE: begin
                o_key_addr = i_start;
                if (i_go) begin
                    n_vis          = '0;
                    n_vis[i_start] = 1'b1;
                    n_cur          = i_start;
                    n_dfs          = i_dfs;
                    n_wp           = '0;
                    n_head         = '0;
                    n_state        = WS_KEYRD;
                end
            end
            WS_KEYRD: begin
                n_cur_key = i_key_rdata;
                n_cnt     = '0;
                n_state   = WS_SCAN;
            end
            WS_SCAN: begin
                // issue one read per cycle, compare the previous one
                if (issue) begin
                    n_cnt  = r_cnt + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = scan_addr;
                end
                if (r_pv && r_pidx != r_cur && !r_vis[r_pidx] &&
                    (i_key_rdata.vowels == r_cur_key.vowels ||
                     i_key_rdata.first == r_cur_key.first)) begin
                    wl_we         = 1'b1;
                    n_wp          = r_wp + CW'(1);
                    n_vis[r_pidx] = 1'b1;
                end
                if (!issue && !r_pv) begin
                    n_state = WS_EMIT;
                end
            end
            WS_EMIT: begin
                n_res_valid  = 1'b1;
                n_res.status = ST_VISIT;
                n_res.node   = NODE_BITS'(r_cur);
                n_res.last   = empty;
                if (empty) begin
                    n_state = WS_IDLE;
                end else begin
                    if (r_dfs) begin
                        n_wp = wp_dec;
                    end else begin
                        n_head = r_head + CW'(1);
                    end
                    n_state = WS_POPRD;
                end
            end
            WS_POPRD: begin
                n_cur      = wl_rdata;
                o_key_addr = wl_rdata;
                n_state    = WS_KEYRD;
            end
            default: begin
                n_state = WS_IDLE;
            end
        endcase
    end

    assign o_busy      = r_state != WS_IDLE;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
endmodule
`default_nettype wire

// ===== hdl/implicit_graph_bfs_dfs_walk.sv =====
// Top level of the implicit graph walker: name store, error results, walk sequencer.
// Name byte, end of name and clear store are accepted only with busy low; an error
//   result strobes in the cycle after its item is accepted, and results cannot stall.
// A walk holds busy high until it is done, so no new item is accepted meanwhile; each visited
//   node is scanned against every stored node by the single key compare, and the final
//   result strobes on the cycle busy drops. Reset empties the store and the current name.
`default_nettype none
module implicit_graph_bfs_dfs_walk #(
    parameter int MAX_NODES = igw_pkg::MAX_NODES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  igw_pkg::t_in_item   i_item,
    output logic                o_strobe,
    output igw_pkg::t_out_item  o_item
);
    import igw_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    logic           accept;
    logic           act_byte, act_end, act_clear, act_walk;
    logic           start_ok;
    logic           store_full;

    // Node count: next free slot of the key store.
    logic [CW-1:0]  r_count, n_count;
    // Error result register; walk results come from the sequencer.
    logic           r_err_valid, n_err_valid;
    t_out_item      r_err, n_err;

    t_key           cur_key;
    t_key           key_rdata;
    logic [NW-1:0]  key_raddr;
    logic           key_we;
    logic           walk_go;
    logic           walk_valid;
    t_out_item      walk_res;

    assign accept    = start && !busy;
    assign act_byte  = accept && (i_item.action == ACT_BYTE);
    assign act_end   = accept && (i_item.action == ACT_END);
    assign act_clear = accept && (i_item.action == ACT_CLEAR);
    assign act_walk  = accept && (i_item.action == ACT_DFS || i_item.action == ACT_BFS);

    assign store_full = r_count == CW'(MAX_NODES);
    assign start_ok   = 7'(i_item.start_node) < 7'(r_count);
    assign key_we     = act_end && !store_full;
    assign walk_go    = act_walk && start_ok;

    igw_name_acc u_name_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_en  (act_byte),
        .i_name_clr (act_end || act_clear),
        .i_char     (i_item.char_code),
        .o_key      (cur_key)
    );

    // Key store: one entry per stored name, written at the node count.
    igw_ram #(
        .WIDTH ($bits(t_key)),
        .DEPTH (MAX_NODES)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (NW'(r_count)),
        .i_wdata (cur_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    igw_walk #(
        .MAX_NODES (MAX_NODES)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (walk_go),
        .i_dfs       (i_item.action == ACT_DFS),
        .i_start     (i_item.start_node[NW-1:0]),
        .i_count     (r_count),
        .o_key_addr  (key_raddr),
        .i_key_rdata (key_rdata),
        .o_busy      (busy),
        .o_res_valid (walk_valid),
        .o_res       (walk_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_err_valid <= n_err_valid;
        end
        r_err <= n_err;
    end

    always_comb begin
        n_count     = r_count;
        n_err_valid = 1'b0;
        n_err       = r_err;
        if (act_clear) begin
            n_count = '0;
        end else if (key_we) begin
            // advance to the next free slot
            n_count = r_count + CW'(1);
        end
        if (act_end && store_full) begin
            // drop the name and report it
            n_err_valid  = 1'b1;
            n_err.status = ST_FULL;
            n_err.node   = '0;
            n_err.last   = 1'b1;
        end else if (act_walk && !start_ok) begin
            n_err_valid  = 1'b1;
            n_err.status = ST_BAD_START;
            n_err.node   = '0;
            n_err.last   = 1'b1;
        end
    end

    // Errors are raised only while idle, so the two sources never overlap.
    assign o_strobe = walk_valid || r_err_valid;
    assign o_item   = walk_valid ? walk_res : r_err;
endmodule
`default_nettype wire
